/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/u2u_pkg.sv */
package u2u_pkg;

	// Result kinds reported on the output stream.
	typedef enum logic [2:0] {
		KIND_UNIT       = 3'd0,
		KIND_DONE       = 3'd1,
		KIND_INCOMPLETE = 3'd2,
		KIND_INVALID    = 3'd3,
		KIND_RANGE      = 3'd4
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_EMIT_UNITS    = 2'd0;
	localparam logic [1:0] REG_BMP_ONLY      = 2'd1;
	localparam logic [1:0] REG_LITTLE_ENDIAN = 2'd2;

	// Configuration bits as seen by the decode logic.
	typedef struct packed {
		logic emit_units;
		logic bmp_only;
		logic little_endian;
	} cfg_t;

	// One result word.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] unit_word;
		logic [15:0] rune_count;
	} res_t;

endpackage

/* rtl/core/u2u_in_stage.sv */
module u2u_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// The input register takes a new word when it is empty or is being consumed.
	assign s_tready = !valid_s1 || advance;

	// Control bit of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Byte payload, loaded only on an accepted word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

/* rtl/core/u2u_step.sv */
module u2u_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    in_byte,
	input  u2u_pkg::cfg_t cfg,
	output logic          res_valid,
	output u2u_pkg::res_t res
);

	logic [2:0]  pending_q;
	logic [31:0] accum_q;
	logic [15:0] runes_q;
	logic        err_q;

	logic [2:0]  pending_d;
	logic [31:0] accum_d;
	logic [15:0] runes_d;
	logic        err_d;

	logic        res_hit;
	logic        fin;
	logic [31:0] rune;
	logic        run;
	logic [2:0]  lead_cnt;
	logic [3:0]  shamt;
	logic [6:0]  lead_mask;
	logic        out_of_range;
	logic [15:0] runes_inc;

	// Number of continuation bytes a lead byte announces: the run of ones from bit 6 down.
	always_comb begin
		run      = 1'b1;
		lead_cnt = '0;
		for (int i = 6; i >= 0; i--) begin
			if (run && in_byte[i]) begin
				lead_cnt = lead_cnt + 3'd1;
			end else begin
				run = 1'b0;
			end
		end
		shamt     = {1'b0, lead_cnt} + 4'd1;
		lead_mask = 7'h7F >> shamt;
	end

	assign runes_inc    = (runes_q == 16'hFFFF) ? runes_q : runes_q + 16'd1;

	// Byte decode and next state.
	always_comb begin
		pending_d     = pending_q;
		accum_d       = accum_q;
		runes_d       = runes_q;
		err_d         = err_q;
		res_hit       = 1'b0;
		res.kind      = u2u_pkg::KIND_UNIT;
		res.unit_word = 16'd0;
		res.rune_count = runes_q;
		fin           = 1'b0;
		rune          = {24'd0, in_byte};

		if (in_byte == 8'd0) begin
			// End of string: report unless an error was already reported.
			if (!err_q) begin
				res_hit  = 1'b1;
				res.kind = (pending_q != 3'd0) ? u2u_pkg::KIND_INCOMPLETE
				                               : u2u_pkg::KIND_DONE;
			end
			pending_d = '0;
			accum_d   = '0;
			runes_d   = '0;
			err_d     = 1'b0;
		end else if (err_q) begin
			// Dropping bytes until the terminator.
		end else if (pending_q != 3'd0) begin
			if (in_byte[7:6] != 2'b10) begin
				pending_d = '0;
				err_d     = 1'b1;
				res_hit   = 1'b1;
				res.kind  = u2u_pkg::KIND_INVALID;
			end else begin
				accum_d   = {accum_q[25:0], in_byte[5:0]};
				pending_d = pending_q - 3'd1;
				rune      = {accum_q[25:0], in_byte[5:0]};
				fin       = (pending_q == 3'd1);
			end
		end else if (!in_byte[7]) begin
			fin = 1'b1;
		end else if (!in_byte[6]) begin
			// Stray continuation byte in lead position.
			err_d    = 1'b1;
			res_hit  = 1'b1;
			res.kind = u2u_pkg::KIND_INVALID;
		end else begin
			pending_d = lead_cnt;
			accum_d   = {25'd0, in_byte[6:0] & lead_mask};
		end

		// Code points above the BMP or inside the surrogate block fail the range check.
		out_of_range = (rune[31:16] != 16'd0) || (rune[15:11] == 5'b11011);

		// A completed rune is range checked (when emit_units or bmp_only is set), counted and possibly emitted.
		if (fin) begin
			if ((cfg.emit_units || cfg.bmp_only) && out_of_range) begin
				err_d    = 1'b1;
				res_hit  = 1'b1;
				res.kind = u2u_pkg::KIND_RANGE;
			end else begin
				runes_d = runes_inc;
				if (cfg.emit_units) begin
					res_hit        = 1'b1;
					res.kind       = u2u_pkg::KIND_UNIT;
					res.rune_count = runes_inc;
					res.unit_word  = cfg.little_endian ? {rune[7:0], rune[15:8]}
					                                   : rune[15:0];
				end
			end
		end
	end

	assign res_valid = fire && res_hit;

	// Decoder state advances once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			accum_q   <= '0;
			runes_q   <= '0;
			err_q     <= 1'b0;
		end else if (fire) begin
			pending_q <= pending_d;
			accum_q   <= accum_d;
			runes_q   <= runes_d;
			err_q     <= err_d;
		end
	end

endmodule

/* rtl/core/u2u_out_stage.sv */
module u2u_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  u2u_pkg::res_t res,
	output logic          advance,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic [2:0]    m_tuser
);

	logic          valid_s2;
	u2u_pkg::res_t res_s2;

	// The pipeline moves whenever the result register is empty or being drained.
	assign advance = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.rune_count, res_s2.unit_word};
	assign m_tuser  = res_s2.kind;

endmodule

/* rtl/core/utf8_to_ucs2_decoder.sv */
// UTF-8 to UCS-2 stream decoder. One UTF-8 byte enters per word on the input
// stream; a zero byte ends the string. The block accepts a byte every clock
// cycle unless the sink stalls it, and gives at most one result per byte. Each
// byte sits in the input register while the single-pass decode feeds the result
// register, from which the sink takes the result word. Input ready drops only
// while the result register holds a word that the sink does not take. Results
// carry the kind in tuser (unit, string done, incomplete, invalid, out of range)
// and the unit and the running rune count in tdata. After the first error in a
// string the block drops bytes without results until the terminating zero byte.
// The configuration registers are written through wr_en, wr_index and wr_data;
// the user must write them only while no string is in flight, since the block
// itself does not enforce it.
module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [0:0]  wr_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] unit_word, [31:16] rune_count
	output logic [2:0]  m_tuser    // [2:0] kind
);

	u2u_pkg::cfg_t cfg_q;
	logic          advance;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          res_valid;
	u2u_pkg::res_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				u2u_pkg::REG_EMIT_UNITS:    cfg_q.emit_units    <= wr_data[0];
				u2u_pkg::REG_BMP_ONLY:      cfg_q.bmp_only      <= wr_data[0];
				u2u_pkg::REG_LITTLE_ENDIAN: cfg_q.little_endian <= wr_data[0];
				default: ;
			endcase
		end
	end

	u2u_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	u2u_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (valid_s1 && advance),
		.in_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	u2u_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* rtl/core/u2u_checker.sv */
`include "assert_macros.svh"

module u2u_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result word holds its payload.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// With the result register empty, the input side never stalls.
	`ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)

	// Only unit results carry a unit value.
	`ASSERT_SAME(a_unit_zero, m_tvalid && (m_tuser != u2u_pkg::KIND_UNIT), m_tdata[15:0] == 16'd0)

	// An emitted unit has always been counted.
	`ASSERT_SAME(a_unit_counted, m_tvalid && (m_tuser == u2u_pkg::KIND_UNIT), m_tdata[31:16] != 16'd0)

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_chk (.*);
